[rtl/tn_pkg.sv]
package tn_pkg;

	localparam int unsigned TICKS_W = 64;
	localparam int unsigned NS_W    = 64;
	localparam int unsigned FREQ_W  = 40;

	localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
	localparam int unsigned MAX_REM_BIT = 33;

	// bits of the scaled fraction quotient; it never exceeds 10^9
	localparam int unsigned FRAC_Q_W = 30;
	localparam int unsigned PROD_W   = 64;

endpackage

[rtl/tn_ticks_if.sv]
interface tn_ticks_if
	import tn_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [TICKS_W-1:0] ticks;

	modport source (output valid, output ticks, input ready);
	modport sink   (input valid, input ticks, output ready);
endinterface

[rtl/tn_ns_if.sv]
interface tn_ns_if
	import tn_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [NS_W-1:0] nanoseconds;
	logic            no_frequency;

	modport source (output valid, output nanoseconds, output no_frequency, input ready);
	modport sink   (input valid, input nanoseconds, input no_frequency, output ready);
endinterface

[rtl/tn_cfg_if.sv]
interface tn_cfg_if
	import tn_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] frequency_hz;

	modport source (output valid, output frequency_hz, input ready);
	modport sink   (input valid, input frequency_hz, output ready);
endinterface

[rtl/ticks_to_nanoseconds_unit.sv]
// Tick-to-nanosecond converter.
// Channels: req (sink) carries ticks; rsp (source) carries nanoseconds and
// no_frequency; cfg (sink) writes frequency_hz, the counter rate in Hz.
// cfg is always ready; write it only while no item is in flight.
// An item is taken on any edge where valid and ready are high. One result
// comes out per item, in order.
// Throughput: one item per cycle unless rsp stalls. An item passes the input
// register, the 64 restoring steps of the ticks / frequency divider, the
// scaling and multiply stages, 30 fraction divider steps, output register.
// The whole pipeline advances as one: when rsp holds a result that is not
// taken, every stage holds and req.ready drops; nothing is lost or repeated.
// Reset clears every valid bit and sets frequency_hz to 0. With frequency 0
// each result is 0 with no_frequency set.
module ticks_to_nanoseconds_unit
	import tn_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	tn_cfg_if.sink     cfg,
	tn_ticks_if.sink   req,
	tn_ns_if.source    rsp
);

	localparam int unsigned D1_STEPS = TICKS_W;
	localparam int unsigned D2_STEPS = FRAC_Q_W;

	logic [FREQ_W-1:0] freq_q;
	logic              adv;

	logic              out_v_q;
	logic [NS_W-1:0]   out_ns_q;
	logic              out_nf_q;

	assign adv       = !out_v_q || rsp.ready;
	assign req.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
		end else if (cfg.valid) begin
			freq_q <= cfg.frequency_hz;
		end
	end

	// divider 1: ticks / freq, one quotient bit per stage
	logic                d1_v_s   [0:D1_STEPS];
	logic [FREQ_W-1:0]   d1_rem_s [0:D1_STEPS];
	logic [TICKS_W-1:0]  d1_nq_s  [0:D1_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_v_s[0] <= 1'b0;
		end else if (adv) begin
			d1_v_s[0] <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_rem_s[0] <= '0;
			d1_nq_s[0]  <= req.ticks;
		end
	end

	for (genvar k = 0; k < D1_STEPS; k++) begin : g_d1
		logic [FREQ_W:0] trial;
		logic            ge;
		assign trial = {d1_rem_s[k], d1_nq_s[k][TICKS_W-1]};
		assign ge    = trial >= {1'b0, freq_q};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				d1_v_s[k+1] <= d1_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d1_rem_s[k+1] <= ge ? FREQ_W'(trial - {1'b0, freq_q}) : trial[FREQ_W-1:0];
				d1_nq_s[k+1]  <= {d1_nq_s[k][TICKS_W-2:0], ge};
			end
		end
	end

	// scale: normalize remainder below 2^34, split whole * 10^9
	logic [FREQ_W-1:0] rem_fin;
	logic [TICKS_W-1:0] quo_fin;
	logic [2:0]        excess;

	assign rem_fin = d1_rem_s[D1_STEPS];
	assign quo_fin = d1_nq_s[D1_STEPS];

	always_comb begin
		excess = 3'd0;
		for (int b = MAX_REM_BIT + 1; b < FREQ_W; b++) begin
			if (rem_fin[b]) begin
				excess = 3'(b - MAX_REM_BIT);
			end
		end
	end

	logic              s2_v_s;
	logic [61:0]       s2_plo_s;
	logic [61:0]       s2_phi_s;
	logic [MAX_REM_BIT:0] s2_rem_s;
	logic [FREQ_W-1:0] s2_fs_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_s <= 1'b0;
		end else if (adv) begin
			s2_v_s <= d1_v_s[D1_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_plo_s <= 62'(quo_fin[31:0]) * 62'(NS_PER_SEC);
			s2_phi_s <= 62'(quo_fin[63:32]) * 62'(NS_PER_SEC);
			s2_rem_s <= (MAX_REM_BIT + 1)'(rem_fin >> excess);
			s2_fs_s  <= freq_q >> excess;
		end
	end

	// multiply: fraction product and whole-part sum
	logic                d2_v_s   [0:D2_STEPS];
	logic [FREQ_W-1:0]   d2_rem_s [0:D2_STEPS];
	logic [FRAC_Q_W-1:0] d2_nq_s  [0:D2_STEPS];
	logic [FREQ_W-1:0]   d2_fs_s  [0:D2_STEPS];
	logic [NS_W-1:0]     d2_wh_s  [0:D2_STEPS];
	logic [PROD_W-1:0]   prod;

	assign prod = PROD_W'(s2_rem_s) * PROD_W'(NS_PER_SEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d2_v_s[0] <= 1'b0;
		end else if (adv) begin
			d2_v_s[0] <= s2_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_rem_s[0] <= FREQ_W'(prod[PROD_W-1:FRAC_Q_W]);
			d2_nq_s[0]  <= prod[FRAC_Q_W-1:0];
			d2_fs_s[0]  <= s2_fs_s;
			d2_wh_s[0]  <= NS_W'(s2_plo_s) + {s2_phi_s[31:0], 32'd0};
		end
	end

	// divider 2: fraction quotient, 30 steps
	for (genvar k = 0; k < D2_STEPS; k++) begin : g_d2
		logic [FREQ_W:0] trial;
		logic            ge;
		assign trial = {d2_rem_s[k], d2_nq_s[k][FRAC_Q_W-1]};
		assign ge    = trial >= {1'b0, d2_fs_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				d2_v_s[k+1] <= d2_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d2_rem_s[k+1] <= ge ? FREQ_W'(trial - {1'b0, d2_fs_s[k]})
					: trial[FREQ_W-1:0];
				d2_nq_s[k+1]  <= {d2_nq_s[k][FRAC_Q_W-2:0], ge};
				d2_fs_s[k+1]  <= d2_fs_s[k];
				d2_wh_s[k+1]  <= d2_wh_s[k];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= d2_v_s[D2_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_nf_q <= freq_q == '0;
			out_ns_q <= (freq_q == '0) ? '0
				: d2_wh_s[D2_STEPS] + NS_W'(d2_nq_s[D2_STEPS]);
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.nanoseconds  = out_ns_q;
	assign rsp.no_frequency = out_nf_q;

`ifndef ASSERT_OFF
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_nf_q |-> out_ns_q == '0)
		else $error("no_frequency result is not zero");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !rsp.ready |-> !req.ready)
		else $error("input taken while output stalled");

	a_frac_rem: assert property (@(posedge clk) disable iff (!arst_n)
		d2_v_s[D2_STEPS] && freq_q != '0 |-> d2_rem_s[D2_STEPS] < d2_fs_s[D2_STEPS])
		else $error("fraction remainder not below divisor");
`endif

endmodule
